FILE: sv/waveform_packet_deframer_core_assert.svh
// Assertion macros used by the deframer core.
`ifndef WAVEFORM_PACKET_DEFRAMER_CORE_ASSERT_SVH
`define WAVEFORM_PACKET_DEFRAMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define WPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define WPD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/wpd_pkg.sv
// Types and constants for the waveform packet deframer.
package wpd_pkg;

	// Sample field extraction and per-waveform sample cap
	localparam int SAMPLE_WIDTH = 12;
	localparam int SAMPLE_LIMIT = 64;
	localparam logic [11:0] SAMPLE_MASK = (SAMPLE_WIDTH >= 12) ? 12'hFFF :
		12'((1 << SAMPLE_WIDTH) - 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER_MATCH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TYPE_MATCH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_WAVEFORMS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SAMPLES   = 2'd3;

	// Header word offsets relative to the packet header word
	localparam logic [2:0] OFS_TYPE   = 3'd2;
	localparam logic [2:0] OFS_BOARD  = 3'd3;
	localparam logic [2:0] OFS_EVENT  = 3'd5;
	localparam logic [2:0] OFS_WCOUNT = 3'd6;

	typedef enum logic [2:0] {
		PH_HUNT = 3'd0,
		PH_HEAD = 3'd1,
		PH_WHDR = 3'd2,
		PH_WCNT = 3'd3,
		PH_SAMP = 3'd4
	} phase_t;

	typedef struct packed {
		logic [31:0] header_match;
		logic [31:0] type_match;
		logic [7:0]  max_waveforms;
		logic [6:0]  max_samples;
	} cfg_t;

	typedef struct packed {
		logic [31:0] data_word;
		logic        end_of_buffer;
	} in_item_t;

	typedef struct packed {
		logic [31:0] board_id;
		logic [31:0] event_number;
		logic [1:0]  asic_column;
		logic [1:0]  asic_row;
		logic [2:0]  asic_channel;
		logic [8:0]  window_number;
		logic [5:0]  sample_index;
		logic [11:0] sample_even;
		logic [11:0] sample_odd;
		logic        pair_valid;
		logic        last_of_waveform;
		logic        aborted;
	} out_item_t;

endpackage

FILE: sv/wpd_cfg.sv
// Configuration register bank of the deframer.
module wpd_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_data,
	output wpd_pkg::cfg_t                cfg
);

	wpd_pkg::cfg_t cfg_q;

	// Register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_match  <= 32'd0;
			cfg_q.type_match    <= 32'd0;
			cfg_q.max_waveforms <= 8'd64;
			cfg_q.max_samples   <= 7'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wpd_pkg::REG_HEADER_MATCH:  cfg_q.header_match  <= cfg_data;
				wpd_pkg::REG_TYPE_MATCH:    cfg_q.type_match    <= cfg_data;
				wpd_pkg::REG_MAX_WAVEFORMS: cfg_q.max_waveforms <= cfg_data[7:0];
				wpd_pkg::REG_MAX_SAMPLES:   cfg_q.max_samples   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: sv/wpd_parser.sv
// Packet parse state machine: one stream word per step, zero or one result.
module wpd_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  wpd_pkg::in_item_t   item,
	input  wpd_pkg::cfg_t       cfg,
	output logic                res_valid,
	output wpd_pkg::out_item_t  res
);

	wpd_pkg::phase_t st_q, st_pre, st_d;
	logic [2:0]  hwi_q, hwi_pre, hwi_d, hwi_inc;
	logic [31:0] board_q, board_d;
	logic [31:0] event_q, event_d;
	logic [7:0]  wleft_q, wleft_d, wleft_dec;
	logic [5:0]  pleft_q, pleft_d;
	logic [15:0] whdr_q, whdr_d;
	logic [4:0]  pcnt_q, pcnt_d;

	logic [31:0] w;
	logic [8:0]  lim;
	logic        cnt_over;
	logic        cnt_empty;
	logic        emit_core;
	logic        eob_cut;
	logic        eob_live;

	assign w         = item.data_word;
	assign hwi_inc   = hwi_q + 3'd1;
	assign wleft_dec = wleft_q - 8'd1;

	// Sample count limit is the smaller of the register and the build cap
	assign lim = ({2'b00, cfg.max_samples} < 9'(wpd_pkg::SAMPLE_LIMIT)) ?
		{2'b00, cfg.max_samples} : 9'(wpd_pkg::SAMPLE_LIMIT);
	assign cnt_over  = w > {23'd0, lim};
	assign cnt_empty = (w[31:1] == 31'd0);

	// Next state, before the end-of-buffer override
	always_comb begin
		st_pre  = st_q;
		hwi_pre = hwi_q;
		board_d = board_q;
		event_d = event_q;
		wleft_d = wleft_q;
		pleft_d = pleft_q;
		whdr_d  = whdr_q;
		pcnt_d  = pcnt_q;
		unique case (st_q)
			wpd_pkg::PH_HEAD: begin
				hwi_pre = hwi_inc;
				if (hwi_inc == wpd_pkg::OFS_TYPE) begin
					if (w != cfg.type_match) begin
						// mismatching word may itself open a new packet
						hwi_pre = 3'd0;
						if (w == cfg.header_match) begin
							st_pre  = wpd_pkg::PH_HEAD;
							board_d = 32'd0;
							event_d = 32'd0;
						end else begin
							st_pre = wpd_pkg::PH_HUNT;
						end
					end
				end else if (hwi_inc == wpd_pkg::OFS_BOARD) begin
					board_d = w;
				end else if (hwi_inc == wpd_pkg::OFS_EVENT) begin
					event_d = w;
				end else if (hwi_inc == wpd_pkg::OFS_WCOUNT) begin
					if (w > {24'd0, cfg.max_waveforms} || w == 32'd0) begin
						st_pre  = wpd_pkg::PH_HUNT;
						hwi_pre = 3'd0;
					end else begin
						wleft_d = w[7:0];
						whdr_d  = 16'd0;
						st_pre  = wpd_pkg::PH_WHDR;
					end
				end
			end
			wpd_pkg::PH_WHDR: begin
				whdr_d = w[15:0];
				st_pre = wpd_pkg::PH_WCNT;
			end
			wpd_pkg::PH_WCNT: begin
				if (cnt_over) begin
					st_pre  = wpd_pkg::PH_HUNT;
					hwi_pre = 3'd0;
				end else if (cnt_empty) begin
					// empty waveform: done at once
					wleft_d = wleft_dec;
					if (wleft_dec == 8'd0) begin
						st_pre  = wpd_pkg::PH_HUNT;
						hwi_pre = 3'd0;
					end else begin
						st_pre = wpd_pkg::PH_WHDR;
					end
				end else begin
					pleft_d = w[6:1];
					pcnt_d  = 5'd0;
					st_pre  = wpd_pkg::PH_SAMP;
				end
			end
			wpd_pkg::PH_SAMP: begin
				pleft_d = pleft_q - 6'd1;
				pcnt_d  = pcnt_q + 5'd1;
				if (pleft_q == 6'd1) begin
					wleft_d = wleft_dec;
					if (wleft_dec == 8'd0) begin
						st_pre  = wpd_pkg::PH_HUNT;
						hwi_pre = 3'd0;
					end else begin
						st_pre = wpd_pkg::PH_WHDR;
					end
				end
			end
			default: begin
				// hunting for a header word
				if (w == cfg.header_match) begin
					st_pre  = wpd_pkg::PH_HEAD;
					hwi_pre = 3'd0;
					board_d = 32'd0;
					event_d = 32'd0;
				end
			end
		endcase
	end

	// Buffer end inside a packet drops back to hunting
	assign eob_cut  = item.end_of_buffer && (st_pre != wpd_pkg::PH_HUNT);
	assign eob_live = eob_cut && ((st_pre != wpd_pkg::PH_HEAD) || (hwi_pre >= wpd_pkg::OFS_TYPE));
	assign st_d     = eob_cut ? wpd_pkg::PH_HUNT : st_pre;
	assign hwi_d    = eob_cut ? 3'd0 : hwi_pre;

	assign emit_core = (st_q == wpd_pkg::PH_SAMP) ||
		((st_q == wpd_pkg::PH_WCNT) && !cnt_over && cnt_empty);

	// Result fields
	always_comb begin
		logic [15:0] hdr;
		hdr = 16'd0;
		if (emit_core || st_pre == wpd_pkg::PH_WCNT || st_pre == wpd_pkg::PH_SAMP) begin
			hdr = whdr_d;
		end
		res_valid            = emit_core || eob_live;
		res.board_id         = board_d;
		res.event_number     = event_d;
		res.asic_column      = hdr[15:14];
		res.asic_row         = hdr[13:12];
		res.asic_channel     = hdr[11:9];
		res.window_number    = hdr[8:0];
		res.pair_valid       = (st_q == wpd_pkg::PH_SAMP);
		res.sample_index     = res.pair_valid ? {pcnt_q, 1'b0} : 6'd0;
		res.sample_even      = res.pair_valid ? (w[11:0] & wpd_pkg::SAMPLE_MASK) : 12'd0;
		res.sample_odd       = res.pair_valid ? (w[27:16] & wpd_pkg::SAMPLE_MASK) : 12'd0;
		res.last_of_waveform = !res.pair_valid || (pleft_q == 6'd1);
		res.aborted          = eob_live;
	end

	// State registers, advanced once per processed word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= wpd_pkg::PH_HUNT;
			hwi_q   <= 3'd0;
			board_q <= 32'd0;
			event_q <= 32'd0;
			wleft_q <= 8'd0;
			pleft_q <= 6'd0;
			whdr_q  <= 16'd0;
			pcnt_q  <= 5'd0;
		end else if (step) begin
			st_q    <= st_d;
			hwi_q   <= hwi_d;
			board_q <= board_d;
			event_q <= event_d;
			wleft_q <= wleft_d;
			pleft_q <= pleft_d;
			whdr_q  <= whdr_d;
			pcnt_q  <= pcnt_d;
		end
	end

endmodule

FILE: sv/waveform_packet_deframer_core.sv
// A word is held in the input register until the parser processes it; its result is
// then registered in the result register, which drives out_valid.
// Throughput: one word per cycle; the input register and the result register
// both move whenever the result register is empty or being taken downstream.
// A word that closes nothing gives no result and is still consumed.
// Reset (arst_n low) empties both registers, returns the parser to hunting and
// loads the configuration defaults; no clearing pass follows.
`include "waveform_packet_deframer_core_assert.svh"

module waveform_packet_deframer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  wpd_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output wpd_pkg::out_item_t            out_data,
	input  logic                          cfg_we,
	input  logic [wpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);

	wpd_pkg::cfg_t      cfg;
	wpd_pkg::in_item_t  item_s1;
	logic               item_v_s1;
	wpd_pkg::out_item_t res;
	logic               res_v;
	wpd_pkg::out_item_t res_s2;
	logic               res_v_s2;
	logic               adv;
	logic               step;

	wpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline moves when the result slot is free or draining
	assign adv      = !res_v_s2 || out_ready;
	assign step     = item_v_s1 && adv;
	assign in_ready = !item_v_s1 || adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (in_ready) begin
			item_v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	wpd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg),
		.res_valid (res_v),
		.res       (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s2 <= 1'b0;
		end else if (adv) begin
			res_v_s2 <= step && res_v;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_v) begin
			res_s2 <= res;
		end
	end

	assign out_valid = res_v_s2;
	assign out_data  = res_s2;

	`WPD_ASSERT_NOW(a_no_step_on_stall, res_v_s2 && !out_ready, !step,
		"word processed while result register is stalled")
	`WPD_ASSERT_NEXT(a_result_lands, step && res_v, out_valid,
		"result of a processed word did not reach the output")
	`WPD_ASSERT_NOW(a_empty_is_last, out_valid && !out_data.pair_valid,
		out_data.last_of_waveform, "result without a pair is not marked last")
	`WPD_ASSERT_NOW(a_empty_zero_samples, out_valid && !out_data.pair_valid,
		out_data.sample_index == 6'd0 && out_data.sample_even == 12'd0 &&
		out_data.sample_odd == 12'd0, "result without a pair carries sample data")

endmodule
